// File: rtl/dtt_pkg.sv
// Shared types and constants of the detection track table.
`timescale 1ns / 1ps
`default_nettype none

package dtt_pkg;

    localparam int SLOTS    = 16;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int COORD_W  = 12;
    localparam int STAMP_W  = 32;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 32;
    localparam int ACT_W    = 5;

    localparam logic [COORD_W-1:0] TOL_RESET  = '0;
    localparam logic [STAMP_W-1:0] LIFE_RESET = 32'd100000;
    localparam logic [ACT_W-1:0]   ACT_RESET  = ACT_W'(SLOTS);

    localparam logic [OP_W-1:0] OP_FRAME  = 2'd0;
    localparam logic [OP_W-1:0] OP_DETECT = 2'd1;
    localparam int OP_READ_BIT = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOL  = 2'd0,
        CFG_LIFE = 2'd1,
        CFG_ACT  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OUT_FRAME = 3'd0,
        OUT_MATCH = 3'd1,
        OUT_ADD   = 3'd2,
        OUT_DROP  = 3'd3,
        OUT_READ  = 3'd4
    } t_outcome;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_AGE,
        S_MATCH,
        S_ALLOC,
        S_READ
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [STAMP_W-1:0] frame_stamp;
        logic [COORD_W-1:0] box_x;
        logic [COORD_W-1:0] box_y;
        logic [COORD_W-1:0] box_w;
        logic [COORD_W-1:0] box_h;
        logic [IDX_W-1:0]   read_index;
    } t_in;

    typedef struct packed {
        logic [2:0]         outcome;
        logic [IDX_W-1:0]   slot;
        logic               slot_valid;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [COORD_W-1:0] out_w;
        logic [COORD_W-1:0] out_h;
        logic [STAMP_W-1:0] out_stamp;
    } t_out;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic     load;
        logic     scan;
        logic     age;
        logic     match;
        logic     alloc_init;
        logic     alloc_step;
        logic     commit;
        logic     frame_end;
        logic     set_full;
        logic     respond;
        t_outcome outcome;
    } t_cmd;

    typedef struct packed {
        logic is_frame;
        logic is_read;
        logic full;
        logic tol_zero;
        logic scan_done;
        logic hit;
        logic vacant;
        logic alloc_last;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/dtt_ctrl.sv
// Sequencing state machine of the detection track table.
`timescale 1ns / 1ps
`default_nettype none

module dtt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire dtt_pkg::t_stat i_stat,
    output dtt_pkg::t_cmd      o_cmd
);

    dtt_pkg::t_state r_state;
    dtt_pkg::t_state n_state;
    dtt_pkg::t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        cmd         = '0;
        cmd.outcome = dtt_pkg::OUT_FRAME;
        unique case (r_state)
            dtt_pkg::S_IDLE: begin
                if (start) begin
                    cmd.load = 1'b1;
                    n_state  = dtt_pkg::S_DECODE;
                end
            end
            dtt_pkg::S_DECODE: begin
                if (i_stat.is_frame) begin
                    cmd.scan = 1'b1;
                    n_state  = dtt_pkg::S_AGE;
                end else if (i_stat.is_read) begin
                    n_state = dtt_pkg::S_READ;
                end else if (i_stat.full) begin
                    cmd.respond = 1'b1;
                    cmd.outcome = dtt_pkg::OUT_DROP;
                    n_state     = dtt_pkg::S_IDLE;
                end else if (i_stat.tol_zero) begin
                    cmd.alloc_init = 1'b1;
                    n_state        = dtt_pkg::S_ALLOC;
                end else begin
                    cmd.scan = 1'b1;
                    n_state  = dtt_pkg::S_MATCH;
                end
            end
            dtt_pkg::S_AGE: begin
                cmd.scan = 1'b1;
                cmd.age  = 1'b1;
                if (i_stat.scan_done) begin
                    cmd.frame_end = 1'b1;
                    cmd.respond   = 1'b1;
                    cmd.outcome   = dtt_pkg::OUT_FRAME;
                    n_state       = dtt_pkg::S_IDLE;
                end
            end
            dtt_pkg::S_MATCH: begin
                cmd.scan  = 1'b1;
                cmd.match = 1'b1;
                if (i_stat.hit) begin
                    cmd.commit  = 1'b1;
                    cmd.respond = 1'b1;
                    cmd.outcome = dtt_pkg::OUT_MATCH;
                    n_state     = dtt_pkg::S_IDLE;
                end else if (i_stat.scan_done) begin
                    cmd.alloc_init = 1'b1;
                    n_state        = dtt_pkg::S_ALLOC;
                end
            end
            dtt_pkg::S_ALLOC: begin
                if (i_stat.vacant) begin
                    cmd.commit  = 1'b1;
                    cmd.respond = 1'b1;
                    cmd.outcome = dtt_pkg::OUT_ADD;
                    n_state     = dtt_pkg::S_IDLE;
                end else if (i_stat.alloc_last) begin
                    cmd.set_full = 1'b1;
                    cmd.respond  = 1'b1;
                    cmd.outcome  = dtt_pkg::OUT_DROP;
                    n_state      = dtt_pkg::S_IDLE;
                end else begin
                    cmd.alloc_step = 1'b1;
                end
            end
            dtt_pkg::S_READ: begin
                cmd.respond = 1'b1;
                cmd.outcome = dtt_pkg::OUT_READ;
                n_state     = dtt_pkg::S_IDLE;
            end
            default: begin
                n_state = dtt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;
    assign busy  = (r_state != dtt_pkg::S_IDLE);

    a_no_resp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtt_pkg::S_IDLE) |-> !cmd.respond)
        else $error("response issued while idle");

    a_resp_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.respond |=> (r_state == dtt_pkg::S_IDLE))
        else $error("item continues after its response");

    a_commit_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> cmd.respond)
        else $error("table write without a response");

endmodule

`default_nettype wire

// File: rtl/dtt_dpath.sv
// Datapath of the detection track table: registers, entry memory, scan and result.
`timescale 1ns / 1ps
`default_nettype none

module dtt_dpath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire dtt_pkg::t_in                    i_in,
    input  wire logic                            i_cfg_we,
    input  wire logic [dtt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [dtt_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire dtt_pkg::t_cmd                   i_cmd,
    output dtt_pkg::t_stat                       o_stat,
    output logic                                 o_done,
    output dtt_pkg::t_out                        o_out
);

    // configuration
    logic [dtt_pkg::COORD_W-1:0] r_tol;
    logic [dtt_pkg::STAMP_W-1:0] r_life;
    logic [dtt_pkg::ACT_W-1:0]   r_act;

    // table state
    logic [dtt_pkg::SLOTS-1:0]   r_occ;
    dtt_pkg::t_entry             mem [dtt_pkg::SLOTS];
    logic [dtt_pkg::STAMP_W-1:0] r_now;
    logic [dtt_pkg::IDX_W-1:0]   r_last;
    logic                        r_full;

    // item and scan
    dtt_pkg::t_in                r_item;
    logic [dtt_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_pv;
    logic [dtt_pkg::IDX_W-1:0]   r_pidx;
    dtt_pkg::t_entry             r_rdata;
    logic [dtt_pkg::IDX_W-1:0]   r_aidx;
    logic [dtt_pkg::CNT_W-1:0]   r_k;

    dtt_pkg::t_out               r_out;
    dtt_pkg::t_out               n_out;
    logic                        r_done;

    logic [dtt_pkg::CNT_W-1:0]   w_n;
    logic                        w_issue;
    logic                        w_hit;
    logic                        w_old;
    logic [dtt_pkg::IDX_W-1:0]   w_widx;
    logic [dtt_pkg::CNT_W-1:0]   w_start;
    logic [dtt_pkg::CNT_W-1:0]   w_next;
    logic [dtt_pkg::STAMP_W-1:0] w_age;
    dtt_pkg::t_entry             w_wdata;

    function automatic logic near(input logic [dtt_pkg::COORD_W-1:0] a,
                                  input logic [dtt_pkg::COORD_W-1:0] b,
                                  input logic [dtt_pkg::COORD_W-1:0] tol);
        logic [dtt_pkg::COORD_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return (d <= tol);
    endfunction

    always_comb begin
        if (r_act == '0) begin
            w_n = dtt_pkg::CNT_W'(1);
        end else if (r_act > dtt_pkg::ACT_W'(dtt_pkg::SLOTS)) begin
            w_n = dtt_pkg::CNT_W'(dtt_pkg::SLOTS);
        end else begin
            w_n = r_act;
        end
    end

    assign w_issue = i_cmd.scan && (r_cnt < w_n);
    assign w_age   = r_now - r_rdata.stamp;
    assign w_old   = (w_age > r_life);
    assign w_hit   = r_pv && r_occ[r_pidx]
                     && near(r_rdata.x, r_item.box_x, r_tol)
                     && near(r_rdata.y, r_item.box_y, r_tol)
                     && near(r_rdata.w, r_item.box_w, r_tol)
                     && near(r_rdata.h, r_item.box_h, r_tol);
    assign w_start = {1'b0, r_last} + dtt_pkg::CNT_W'(1);
    assign w_next  = {1'b0, r_aidx} + dtt_pkg::CNT_W'(1);
    assign w_widx  = (i_cmd.outcome == dtt_pkg::OUT_MATCH) ? r_pidx : r_aidx;

    assign w_wdata.x     = r_item.box_x;
    assign w_wdata.y     = r_item.box_y;
    assign w_wdata.w     = r_item.box_w;
    assign w_wdata.h     = r_item.box_h;
    assign w_wdata.stamp = r_now;

    always_comb begin
        o_stat            = '0;
        o_stat.is_frame   = (r_item.op == dtt_pkg::OP_FRAME);
        o_stat.is_read    = r_item.op[dtt_pkg::OP_READ_BIT];
        o_stat.full       = r_full;
        o_stat.tol_zero   = (r_tol == '0);
        o_stat.scan_done  = (r_cnt >= w_n) && !r_pv;
        o_stat.hit        = i_cmd.match && w_hit;
        o_stat.vacant     = !r_occ[r_aidx];
        o_stat.alloc_last = (r_k == (w_n - dtt_pkg::CNT_W'(1)));
    end

    // result word
    always_comb begin
        n_out         = '0;
        n_out.outcome = i_cmd.outcome;
        case (i_cmd.outcome) inside
            dtt_pkg::OUT_MATCH, dtt_pkg::OUT_ADD: begin
                n_out.slot       = w_widx;
                n_out.slot_valid = 1'b1;
                n_out.out_x      = w_wdata.x;
                n_out.out_y      = w_wdata.y;
                n_out.out_w      = w_wdata.w;
                n_out.out_h      = w_wdata.h;
                n_out.out_stamp  = w_wdata.stamp;
            end
            dtt_pkg::OUT_READ: begin
                n_out.slot       = r_item.read_index;
                n_out.slot_valid = r_occ[r_item.read_index];
                n_out.out_x      = r_rdata.x;
                n_out.out_y      = r_rdata.y;
                n_out.out_w      = r_rdata.w;
                n_out.out_h      = r_rdata.h;
                n_out.out_stamp  = r_rdata.stamp;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= dtt_pkg::TOL_RESET;
            r_life <= dtt_pkg::LIFE_RESET;
            r_act  <= dtt_pkg::ACT_RESET;
            r_occ  <= '0;
            r_now  <= '0;
            r_last <= '0;
            r_full <= 1'b0;
            r_cnt  <= '0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dtt_pkg::CFG_TOL:  r_tol  <= i_cfg_data[dtt_pkg::COORD_W-1:0];
                    dtt_pkg::CFG_LIFE: r_life <= i_cfg_data[dtt_pkg::STAMP_W-1:0];
                    dtt_pkg::CFG_ACT:  r_act  <= i_cfg_data[dtt_pkg::ACT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_cnt <= i_in.op[dtt_pkg::OP_READ_BIT] ? {1'b0, i_in.read_index} : '0;
                if (i_in.op == dtt_pkg::OP_FRAME) begin
                    r_now <= i_in.frame_stamp;
                end
            end else if (w_issue) begin
                r_cnt <= r_cnt + dtt_pkg::CNT_W'(1);
            end
            r_pv <= w_issue;
            if (i_cmd.age && r_pv && w_old) begin
                r_occ[r_pidx] <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_occ[w_widx] <= 1'b1;
                if (i_cmd.outcome == dtt_pkg::OUT_ADD) begin
                    r_last <= r_aidx;
                end
            end
            if (i_cmd.frame_end) begin
                r_last <= dtt_pkg::IDX_W'(w_n - dtt_pkg::CNT_W'(1));
                r_full <= 1'b0;
            end
            if (i_cmd.set_full) begin
                r_full <= 1'b1;
            end
            r_done <= i_cmd.respond;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            mem[w_widx] <= w_wdata;
        end
        r_rdata <= mem[r_cnt[dtt_pkg::IDX_W-1:0]];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
        r_pidx <= r_cnt[dtt_pkg::IDX_W-1:0];
        if (i_cmd.alloc_init) begin
            r_aidx <= (w_start >= w_n) ? '0 : w_start[dtt_pkg::IDX_W-1:0];
            r_k    <= '0;
        end else if (i_cmd.alloc_step) begin
            r_aidx <= (w_next >= w_n) ? '0 : w_next[dtt_pkg::IDX_W-1:0];
            r_k    <= r_k + dtt_pkg::CNT_W'(1);
        end
        if (i_cmd.respond) begin
            r_out <= n_out;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

    a_commit_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_occ[$past(w_widx)])
        else $error("written entry not marked occupied");

    a_full_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_full) |-> $past(i_cmd.set_full))
        else $error("full flag set without a failed vacancy search");

endmodule

`default_nettype wire

// File: rtl/detection_track_table.sv
// Top level of the detection track table: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command channel: drive i_in and raise start; the item transfers at a rising
//   edge where start is high and busy is low. op 0 starts a frame (ages out
//   entries), op 1 presents a detection, op 2 or 3 reads entry read_index.
//   Result channel: exactly one result per item, shown on o_out for one cycle
//   with o_done high. The receiver cannot hold it off.
//   Configuration: i_cfg_we, i_cfg_index (0 tolerance, 1 lifetime, 2 active
//   slots), i_cfg_data; written at the edge. The user writes only while idle;
//   the block itself does not enforce it. Per item, n = active slots: a read
//   fetches entry read_index; a frame ages out entries over n slots; a
//   detection is dropped at once while full, else scans n slots for a match
//   (skipped at zero tolerance), then up to n for a vacancy. The entry memory
//   is read once per cycle on its one read port, pacing frame and match scans.
//   busy falls in the cycle o_done is shown, so the next item may transfer
//   there. Items are taken one at a time.
//   Reset (synchronous, i_rst_n low) clears all occupied marks, the frame
//   stamp, the allocation pointer and the full flag, and loads register
//   defaults; the box memory is not cleared.

module detection_track_table (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire dtt_pkg::t_in                    i_in,
    output logic                                 o_done,
    output dtt_pkg::t_out                        o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [dtt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [dtt_pkg::CFG_W-1:0]       i_cfg_data
);

    dtt_pkg::t_cmd  cmd;
    dtt_pkg::t_stat stat;

    dtt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    dtt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_done      (o_done),
        .o_out       (o_out)
    );

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while an item is still in work");

endmodule

`default_nettype wire
